### rtl/i2da_pkg.sv
package i2da_pkg;

	localparam int VALUE_WIDTH = 32;
	localparam int CHAR_W      = 6;

	// decimal digits needed for the largest magnitude, 2**(VALUE_WIDTH-1)
	function automatic int digit_count(int width);
		longint unsigned m;
		int n;
		m = 64'd1 << (width - 1);
		n = 0;
		do begin
			n++;
			m = m / 10;
		end while (m != 0);
		return n;
	endfunction

	localparam int DIGITS     = digit_count(VALUE_WIDTH);
	localparam int BCD_W      = DIGITS * 4;
	localparam int IDX_W      = $clog2(DIGITS);
	localparam int STEP_BITS  = 4;
	localparam int NUM_DD     = (VALUE_WIDTH + STEP_BITS - 1) / STEP_BITS;
	localparam int PAD_W      = NUM_DD * STEP_BITS;

	localparam logic [CHAR_W-1:0] ASCII_ZERO  = 6'd48;
	localparam logic [CHAR_W-1:0] ASCII_MINUS = 6'd45;

	typedef logic [DIGITS-1:0][3:0] bcd_t;

	// one shift-add-3 step of the binary to bcd conversion
	function automatic bcd_t dabble_step(bcd_t b, logic din);
		bcd_t t;
		logic [BCD_W-1:0] flat;
		t = b;
		for (int d = 0; d < DIGITS; d++) begin
			if (t[d] >= 4'd5) begin
				t[d] = t[d] + 4'd3;
			end
		end
		flat = t;
		return bcd_t'({flat[BCD_W-2:0], din});
	endfunction

endpackage

### rtl/i2da_value_if.sv
interface i2da_value_if import i2da_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic [VALUE_WIDTH-1:0] value;

	modport source (output valid, output value, input ready);
	modport sink   (input valid, input value, output ready);
endinterface

### rtl/i2da_char_if.sv
interface i2da_char_if import i2da_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [CHAR_W-1:0] character;
	logic              last;

	modport source (output valid, output character, output last, input ready);
	modport sink   (input valid, input character, input last, output ready);
endinterface

### rtl/int_to_decimal_ascii.sv
// channel  | direction | payload                     | handshake
// number   | in        | value[VALUE_WIDTH-1:0] s    | valid/ready
// text     | out       | character[5:0], last        | valid/ready
//
// a number passes a sign/magnitude stage and NUM_DD stages of 4 binary-to-bcd
// steps each (9 stages in all at width 32); each number then gives 1 to 11
// characters, one character per cycle from the output register while text is
// ready, with no gap between numbers.
// reset clears the stage valid bits and the serializer; a stall on text holds
// every stage that is full and lets bubbles close up.
module int_to_decimal_ascii import i2da_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	i2da_value_if.sink   number,
	i2da_char_if.source  text
);

	logic                   v_s1;
	logic                   neg_s1;
	logic [PAD_W-1:0]       mag_s1;

	logic                   dd_v_s   [NUM_DD];
	logic                   dd_neg_s [NUM_DD];
	bcd_t                   dd_bcd_s [NUM_DD];
	logic [PAD_W-1:0]       dd_bin_s [NUM_DD];

	logic                   src_v    [NUM_DD];
	logic                   src_neg  [NUM_DD];
	bcd_t                   src_bcd  [NUM_DD];
	logic [PAD_W-1:0]       src_bin  [NUM_DD];
	bcd_t                   nxt_bcd  [NUM_DD];
	logic [PAD_W-1:0]       nxt_bin  [NUM_DD];
	logic                   rdy      [NUM_DD+1];

	logic                   busy_q;
	logic                   sign_pend_q;
	bcd_t                   digbuf_q;
	logic [IDX_W-1:0]       idx_q;
	logic [IDX_W-1:0]       lead;
	logic                   load_ok;
	logic                   take;
	logic                   fire;
	logic                   rdy_s1;
	logic [VALUE_WIDTH-1:0] neg_val;

	// sign and magnitude
	assign rdy_s1       = !v_s1 || rdy[0];
	assign number.ready = rdy_s1;
	assign neg_val      = ~number.value + VALUE_WIDTH'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (rdy_s1) begin
			v_s1 <= number.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && number.valid) begin
			neg_s1 <= number.value[VALUE_WIDTH-1];
			mag_s1 <= PAD_W'(number.value[VALUE_WIDTH-1] ? neg_val : number.value);
		end
	end

	// binary to bcd stages
	for (genvar k = 0; k < NUM_DD; k++) begin : g_dd
		if (k == 0) begin : g_first
			assign src_v[k]   = v_s1;
			assign src_neg[k] = neg_s1;
			assign src_bcd[k] = '0;
			assign src_bin[k] = mag_s1;
		end else begin : g_rest
			assign src_v[k]   = dd_v_s[k-1];
			assign src_neg[k] = dd_neg_s[k-1];
			assign src_bcd[k] = dd_bcd_s[k-1];
			assign src_bin[k] = dd_bin_s[k-1];
		end

		assign rdy[k] = !dd_v_s[k] || rdy[k+1];

		always_comb begin
			bcd_t b;
			logic [PAD_W-1:0] r;
			b = src_bcd[k];
			r = src_bin[k];
			for (int j = 0; j < STEP_BITS; j++) begin
				b = dabble_step(b, r[PAD_W-1]);
				r = r << 1;
			end
			nxt_bcd[k] = b;
			nxt_bin[k] = r;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dd_v_s[k] <= 1'b0;
			end else if (rdy[k]) begin
				dd_v_s[k] <= src_v[k];
			end
		end

		always_ff @(posedge clk) begin
			if (rdy[k] && src_v[k]) begin
				dd_neg_s[k] <= src_neg[k];
				dd_bcd_s[k] <= nxt_bcd[k];
				dd_bin_s[k] <= nxt_bin[k];
			end
		end
	end

	// serializer: sign first, then digits from the leading nonzero one
	assign fire    = busy_q && text.ready;
	assign load_ok = !busy_q || (text.ready && !sign_pend_q && idx_q == '0);
	assign take    = dd_v_s[NUM_DD-1] && load_ok;
	assign rdy[NUM_DD] = load_ok;

	always_comb begin
		lead = '0;
		for (int d = 0; d < DIGITS; d++) begin
			if (dd_bcd_s[NUM_DD-1][d] != 4'd0) begin
				lead = IDX_W'(d);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			sign_pend_q <= 1'b0;
			idx_q       <= '0;
		end else if (take) begin
			busy_q      <= 1'b1;
			sign_pend_q <= dd_neg_s[NUM_DD-1];
			idx_q       <= lead;
		end else if (fire) begin
			if (sign_pend_q) begin
				sign_pend_q <= 1'b0;
			end else if (idx_q == '0) begin
				busy_q <= 1'b0;
			end else begin
				idx_q <= idx_q - IDX_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			digbuf_q <= dd_bcd_s[NUM_DD-1];
		end
	end

	assign text.valid     = busy_q;
	assign text.character = sign_pend_q ? ASCII_MINUS
	                                     : ASCII_ZERO + {2'b00, digbuf_q[idx_q]};
	assign text.last      = !sign_pend_q && idx_q == '0;

endmodule
